// ===== hdl/twce_pkg.sv =====
// Shared types and constants for the text window cursor engine.
// Holds control-code names, register map, configuration and result structs.
// Depends on nothing.
package twce_pkg;

  // Control codes
  localparam logic [7:0] CODE_BELL      = 8'd7;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_LF        = 8'd10;
  localparam logic [7:0] CODE_HOME      = 8'd11;
  localparam logic [7:0] CODE_FF        = 8'd12;
  localparam logic [7:0] CODE_CR        = 8'd13;
  localparam logic [7:0] CODE_RIGHT     = 8'd28;
  localparam logic [7:0] CODE_LEFT      = 8'd29;
  localparam logic [7:0] CODE_ROW_INC   = 8'd30;
  localparam logic [7:0] CODE_ROW_DEC   = 8'd31;
  localparam logic [7:0] CODE_PRINT_MIN = 8'd32;

  // Register map, word index = paddr[4:2]
  localparam int unsigned PADDR_WIDTH = 5;
  localparam logic [2:0] REG_WIN_COL    = 3'd0;
  localparam logic [2:0] REG_WIN_ROW    = 3'd1;
  localparam logic [2:0] REG_WIN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_WIN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_TEXT_COLOR = 3'd4;

  localparam logic [7:0] RST_WIN_COL    = 8'd0;
  localparam logic [7:0] RST_WIN_ROW    = 8'd0;
  localparam logic [7:0] RST_WIN_WIDTH  = 8'd80;
  localparam logic [7:0] RST_WIN_HEIGHT = 8'd25;
  localparam logic [7:0] RST_TEXT_COLOR = 8'd7;

  typedef struct packed {
    logic [7:0] win_col;
    logic [7:0] win_row;
    logic [7:0] win_width;
    logic [7:0] win_height;
    logic [7:0] text_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0] scroll_lines;
    logic       write_valid;
    logic [7:0] write_glyph;
    logic [8:0] write_row;
    logic [8:0] write_col;
    logic [7:0] write_color;
    logic       beep_pulse;
  } result_t;

endpackage

// ===== hdl/twce_apb_regs.sv =====
// APB-style configuration registers of the text window cursor engine.
// Depends on twce_pkg (register map, reset values, cfg_t).
module twce_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [twce_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output twce_pkg::cfg_t                   cfg_o
);

  twce_pkg::cfg_t cfg_q;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_col    <= twce_pkg::RST_WIN_COL;
      cfg_q.win_row    <= twce_pkg::RST_WIN_ROW;
      cfg_q.win_width  <= twce_pkg::RST_WIN_WIDTH;
      cfg_q.win_height <= twce_pkg::RST_WIN_HEIGHT;
      cfg_q.text_color <= twce_pkg::RST_TEXT_COLOR;
    end else if (wr_en) begin
      unique case (idx)
        twce_pkg::REG_WIN_COL:    cfg_q.win_col    <= pwdata[7:0];
        twce_pkg::REG_WIN_ROW:    cfg_q.win_row    <= pwdata[7:0];
        twce_pkg::REG_WIN_WIDTH:  cfg_q.win_width  <= pwdata[7:0];
        twce_pkg::REG_WIN_HEIGHT: cfg_q.win_height <= pwdata[7:0];
        twce_pkg::REG_TEXT_COLOR: cfg_q.text_color <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      twce_pkg::REG_WIN_COL:    prdata = {24'd0, cfg_q.win_col};
      twce_pkg::REG_WIN_ROW:    prdata = {24'd0, cfg_q.win_row};
      twce_pkg::REG_WIN_WIDTH:  prdata = {24'd0, cfg_q.win_width};
      twce_pkg::REG_WIN_HEIGHT: prdata = {24'd0, cfg_q.win_height};
      twce_pkg::REG_TEXT_COLOR: prdata = {24'd0, cfg_q.text_color};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/twce_cursor_step.sv =====
// Cursor register and one-character update logic of the text window cursor engine.
// Depends on twce_pkg (control codes, cfg_t, result_t).
module twce_cursor_step #(
  parameter int unsigned COORD_WIDTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [7:0]        code_i,
  input  twce_pkg::cfg_t    cfg_i,
  output twce_pkg::result_t res_o
);

  localparam int unsigned IW = ((COORD_WIDTH > 8) ? COORD_WIDTH : 8) + 1;
  localparam logic [IW-1:0] CoordMax = IW'((1 << COORD_WIDTH) - 1);

  logic [COORD_WIDTH-1:0] col_q, col_d;
  logic [COORD_WIDTH-1:0] row_q, row_d;

  logic [7:0]    w, h;
  logic [IW-1:0] x, y, scroll;
  logic [IW:0]   scroll_tot, wsum_row, wsum_col;
  logic          wr, beep, ff;

  always_comb begin
    w    = (cfg_i.win_width  == 8'd0) ? 8'd1 : cfg_i.win_width;
    h    = (cfg_i.win_height == 8'd0) ? 8'd1 : cfg_i.win_height;
    x    = IW'(col_q);
    y    = IW'(row_q);
    scroll = '0;
    wr   = 1'b0;
    beep = 1'b0;
    ff   = 1'b0;

    // resolve a cursor left outside the window by the previous word
    if (x >= IW'(w)) begin
      x = '0;
      y = y + IW'(1);
    end
    if (y >= IW'(h)) begin
      scroll = y - IW'(h) + IW'(1);
      y      = IW'(h) - IW'(1);
    end

    if (code_i >= twce_pkg::CODE_PRINT_MIN) begin
      wr = 1'b1;
    end else begin
      unique case (code_i)
        twce_pkg::CODE_LF: begin
          y = y + IW'(1);
          x = '0;
        end
        twce_pkg::CODE_CR:   x = '0;
        twce_pkg::CODE_BELL: beep = 1'b1;
        twce_pkg::CODE_BACKSPACE: begin
          if (x != '0) begin
            x = x - IW'(1);
          end else if (y != '0) begin
            y = y - IW'(1);
            x = IW'(w) - IW'(1);
          end
        end
        twce_pkg::CODE_FF: begin
          ff = 1'b1;
          x  = '0;
          y  = '0;
        end
        twce_pkg::CODE_HOME: begin
          x = '0;
          y = '0;
        end
        twce_pkg::CODE_RIGHT: x = x + IW'(1);
        twce_pkg::CODE_LEFT: begin
          if (x != '0) x = x - IW'(1);
        end
        twce_pkg::CODE_ROW_INC: y = y + IW'(1);
        twce_pkg::CODE_ROW_DEC: begin
          if (y != '0) y = y - IW'(1);
        end
        default: wr = 1'b1;
      endcase
    end

    scroll_tot = (IW+1)'(scroll) + (ff ? (IW+1)'(h) : '0);
    wsum_row   = (IW+1)'(cfg_i.win_row) + (IW+1)'(y);
    wsum_col   = (IW+1)'(cfg_i.win_col) + (IW+1)'(x);

    res_o.scroll_lines = (scroll_tot > (IW+1)'(255)) ? 8'hFF : scroll_tot[7:0];
    res_o.write_valid  = wr;
    res_o.write_glyph  = wr ? code_i : 8'd0;
    res_o.write_row    = wr ? wsum_row[8:0] : 9'd0;
    res_o.write_col    = wr ? wsum_col[8:0] : 9'd0;
    res_o.write_color  = cfg_i.text_color;
    res_o.beep_pulse   = beep;

    if (wr) x = x + IW'(1);

    // saturate into the cursor register width
    col_d = (x > CoordMax) ? CoordMax[COORD_WIDTH-1:0] : x[COORD_WIDTH-1:0];
    row_d = (y > CoordMax) ? CoordMax[COORD_WIDTH-1:0] : y[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hdl/text_window_cursor_engine_top.sv =====
// Text window cursor engine: one character code in, one scroll/write/beep word out.
// A character is held in the input register, then its word in the result register.
// Throughput: one word per cycle while the result side does not stall; the cursor update
// between the input and result registers is a few narrow adds and compares.
// Reset (rst_ni low, asynchronous): cursor to home, both stages empty, window
// registers to column 0, row 0, 80 x 25, colour 7.
module text_window_cursor_engine_top #(
  parameter int unsigned COORD_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [twce_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // character input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       char_code_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       scroll_lines_o,
  output logic                             write_valid_o,
  output logic [7:0]                       write_glyph_o,
  output logic [8:0]                       write_row_o,
  output logic [8:0]                       write_col_o,
  output logic [7:0]                       write_color_o,
  output logic                             beep_pulse_o
);

  twce_pkg::cfg_t    cfg;
  twce_pkg::result_t step_res;
  twce_pkg::result_t res_q;

  logic       in_vld_q;
  logic [7:0] code_q;
  logic       out_vld_q;
  logic       advance;
  logic       in_take;

  // Window and colour registers behind the APB-style port.
  twce_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held word into the result register whenever that register is
  // empty or its word is being taken this cycle. The cursor moves on the same
  // edge, so the next held word always sees the cursor its predecessor left.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  // Stall the input only while the held word cannot move on.
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  twce_cursor_step #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .code_i    (code_q),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  // Input register: hold the character until it has been worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      code_q <= char_code_i;
    end
  end

  // Result register: a stalled word holds; drop it once taken unless a new
  // one replaces it on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign scroll_lines_o = res_q.scroll_lines;
  assign write_valid_o  = res_q.write_valid;
  assign write_glyph_o  = res_q.write_glyph;
  assign write_row_o    = res_q.write_row;
  assign write_col_o    = res_q.write_col;
  assign write_color_o  = res_q.write_color;
  assign beep_pulse_o   = res_q.beep_pulse;

`ifndef SYNTHESIS
  // A word without a glyph write carries zeroed write coordinates.
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_valid_o) |->
      (write_glyph_o == 8'd0 && write_row_o == 9'd0 && write_col_o == 9'd0))
    else $error("write fields not cleared on a non-write word");

  // Bell never writes a glyph.
  a_beep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(beep_pulse_o && write_valid_o))
    else $error("beep and glyph write in the same word");

  // The input stalls only while a word is held that cannot move on.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked word");

  // A word that advances is shown at the outputs on the next edge.
  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced word missing from the result register");
`endif

endmodule

// ===== verif/tb_text_window_cursor_engine_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_window_cursor_engine_top: directed and random characters,
// with each result word checked against a cycle-free model of the cursor and window.
// Depends on twce_pkg and the engine RTL only.
module tb_text_window_cursor_engine_top;
  import twce_pkg::*;

  localparam int unsigned COORD_W     = 8;
  localparam int unsigned COORD_MAX   = (1 << COORD_W) - 1;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 40;

  typedef enum int unsigned {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;
  typedef enum logic {ROW_CHAR, ROW_REG} row_kind_e;

  // One line of the directed stimulus: a character or a register write
  typedef struct packed {
    row_kind_e  kind;
    logic [2:0] reg_idx;
    logic [7:0] value;
    logic       typed;
    result_t    word;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr       = '0;
  logic [31:0]            pwdata      = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             char_code_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [7:0]             scroll_lines_o;
  logic                   write_valid_o;
  logic [7:0]             write_glyph_o;
  logic [8:0]             write_row_o;
  logic [8:0]             write_col_o;
  logic [7:0]             write_color_o;
  logic                   beep_pulse_o;

  // Shadow of the window registers and the cursor, advanced once per accepted character
  cfg_t                   win_cfg;
  logic [COORD_W-1:0]     cur_col;
  logic [COORD_W-1:0]     cur_row;

  result_t                pending_words[$];
  stim_row_t              dir_rows[$];
  result_t                want_w;
  result_t                got_w;

  int unsigned            src_idle_pct  = 0;
  int unsigned            sink_stall_pct = 0;
  int unsigned            hold_tag  = 0;
  int unsigned            hold_seen = 0;
  int unsigned            hold_left = 0;
  int unsigned            cycle_cnt = 0;
  int unsigned            errors    = 0;
  int unsigned            words_checked = 0;
  int unsigned            n_directed = 0;
  int unsigned            n_random   = 0;
  int unsigned            n_settings = 0;
  int unsigned            max_scroll = 0;
  cfg_t                   phase_cfg;
  logic [7:0]             code_v;

  text_window_cursor_engine_top #(
    .COORD_WIDTH(COORD_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scroll_lines_o (scroll_lines_o),
    .write_valid_o  (write_valid_o),
    .write_glyph_o  (write_glyph_o),
    .write_row_o    (write_row_o),
    .write_col_o    (write_col_o),
    .write_color_o  (write_color_o),
    .beep_pulse_o   (beep_pulse_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Work out the word the engine owes for one character and advance the shadow cursor.
  // Wrap a column past the width first, then scroll a row past the height, then act.
  function automatic result_t cursor_step(logic [7:0] code);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned scroll;
    result_t     r;
    w = (win_cfg.win_width == 8'd0) ? 1 : int'(win_cfg.win_width);
    h = (win_cfg.win_height == 8'd0) ? 1 : int'(win_cfg.win_height);
    x = cur_col;
    y = cur_row;
    scroll = 0;
    r = '0;
    r.write_color = win_cfg.text_color;
    if (x >= w) begin
      x = 0;
      y = y + 1;
    end
    if (y >= h) begin
      scroll = y - h + 1;
      y = h - 1;
    end
    if (code >= CODE_PRINT_MIN) begin
      r.write_valid = 1'b1;
    end else begin
      case (code)
        CODE_LF: begin
          y = y + 1;
          x = 0;
        end
        CODE_CR:   x = 0;
        CODE_BELL: r.beep_pulse = 1'b1;
        CODE_BACKSPACE: begin
          // step back, or reverse-wrap to the end of the row above; stay put at top-left
          if (x > 0) begin
            x = x - 1;
          end else if (y > 0) begin
            y = y - 1;
            x = w - 1;
          end
        end
        CODE_FF: begin
          scroll = scroll + h;
          x = 0;
          y = 0;
        end
        CODE_HOME: begin
          x = 0;
          y = 0;
        end
        CODE_RIGHT:   x = x + 1;
        CODE_LEFT:    if (x > 0) x = x - 1;
        CODE_ROW_INC: y = y + 1;
        CODE_ROW_DEC: if (y > 0) y = y - 1;
        default:      r.write_valid = 1'b1;
      endcase
    end
    if (r.write_valid) begin
      r.write_glyph = code;
      r.write_row   = 9'(int'(win_cfg.win_row) + y);
      r.write_col   = 9'(int'(win_cfg.win_col) + x);
      x = x + 1;
    end
    cur_col = (x > COORD_MAX) ? COORD_W'(COORD_MAX) : COORD_W'(x);
    cur_row = (y > COORD_MAX) ? COORD_W'(COORD_MAX) : COORD_W'(y);
    r.scroll_lines = (scroll > 255) ? 8'd255 : 8'(scroll);
    return r;
  endfunction

  function automatic result_t word_of(logic [7:0] sc, logic wv, logic [7:0] g,
                                      logic [8:0] row, logic [8:0] col,
                                      logic [7:0] colour, logic bp);
    return '{sc, wv, g, row, col, colour, bp};
  endfunction

  function automatic stim_row_t char_row(logic [7:0] code);
    return '{ROW_CHAR, REG_WIN_COL, code, 1'b0, '0};
  endfunction

  function automatic stim_row_t typed_row(logic [7:0] code, result_t w);
    return '{ROW_CHAR, REG_WIN_COL, code, 1'b1, w};
  endfunction

  function automatic stim_row_t reg_row(logic [2:0] idx, logic [7:0] val);
    return '{ROW_REG, idx, val, 1'b0, '0};
  endfunction

  // Report one field; returns 1 on a mismatch
  function automatic int unsigned field_ok(string name, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      if (errors < MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      case ($urandom_range(9))
        0: return CODE_BELL;
        1: return CODE_BACKSPACE;
        2: return CODE_LF;
        3: return CODE_HOME;
        4: return CODE_FF;
        5: return CODE_CR;
        6: return CODE_RIGHT;
        7: return CODE_LEFT;
        8: return CODE_ROW_INC;
        default: return CODE_ROW_DEC;
      endcase
    end
    if (r < 55) return 8'($urandom_range(31));
    return 8'($urandom_range(255, 32));
  endfunction

  // Bias towards the extremes and, for the window size, towards small windows
  function automatic logic [7:0] pick_reg_value(logic [2:0] idx);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    if ((idx == REG_WIN_WIDTH || idx == REG_WIN_HEIGHT) && r < 65)
      return 8'($urandom_range(12, 1));
    return 8'($urandom_range(255));
  endfunction

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      IDLE_SRC: begin
        src_idle_pct = 50;
        sink_stall_pct = 0;
      end
      IDLE_SINK: begin
        src_idle_pct = 0;
        sink_stall_pct = 50;
      end
      default: begin
        src_idle_pct = 22;
        sink_stall_pct = 22;
      end
    endcase
  endtask

  // Two-phase APB write; the register takes the value at the access edge
  task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIN_COL:    win_cfg.win_col    = val;
      REG_WIN_ROW:    win_cfg.win_row    = val;
      REG_WIN_WIDTH:  win_cfg.win_width  = val;
      REG_WIN_HEIGHT: win_cfg.win_height = val;
      default:        win_cfg.text_color = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_window(cfg_t c);
    cfg_write(REG_WIN_COL, c.win_col);
    cfg_write(REG_WIN_ROW, c.win_row);
    cfg_write(REG_WIN_WIDTH, c.win_width);
    cfg_write(REG_WIN_HEIGHT, c.win_height);
    cfg_write(REG_TEXT_COLOR, c.text_color);
    n_settings++;
  endtask

  // Drop valid and hold until every owed word is back, then let the pipe settle
  task automatic drain_words(int unsigned extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // Offer one character, with random idle cycles first, and hold it until taken
  task automatic send_code(logic [7:0] code, logic typed, result_t word);
    result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = cursor_step(code);
    if (pred.scroll_lines > max_scroll) max_scroll = pred.scroll_lines;
    pending_words.push_back(typed ? word : pred);
  endtask

  // Result side: check each accepted word, then decide the stall for the next cycle.
  // A long hold-off is requested by bumping hold_tag and counted down here.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_w = '{scroll_lines_o, write_valid_o, write_glyph_o, write_row_o, write_col_o,
                write_color_o, beep_pulse_o};
      if (pending_words.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t ns: result word with nothing owed, got %h", $time, got_w);
        errors++;
      end else begin
        want_w = pending_words.pop_front();
        errors += field_ok("scroll_lines", 9'(want_w.scroll_lines), 9'(got_w.scroll_lines));
        errors += field_ok("write_valid", 9'(want_w.write_valid), 9'(got_w.write_valid));
        errors += field_ok("write_glyph", 9'(want_w.write_glyph), 9'(got_w.write_glyph));
        errors += field_ok("write_row", want_w.write_row, got_w.write_row);
        errors += field_ok("write_col", want_w.write_col, got_w.write_col);
        errors += field_ok("write_color", 9'(want_w.write_color), 9'(got_w.write_color));
        errors += field_ok("beep_pulse", 9'(want_w.beep_pulse), 9'(got_w.beep_pulse));
        words_checked++;
      end
    end
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still owed", cycle_cnt,
               pending_words.size());
      $display("tb_text_window_cursor_engine_top NOT OK");
      $finish;
    end
  end

  initial begin
    win_cfg = '{RST_WIN_COL, RST_WIN_ROW, RST_WIN_WIDTH, RST_WIN_HEIGHT, RST_TEXT_COLOR};
    cur_col = '0;
    cur_row = '0;

    // Directed rows: reset window first, expected words typed in where obvious
    dir_rows.push_back(typed_row(8'h41, word_of(8'd0, 1'b1, 8'h41, 9'd0, 9'd0, 8'd7, 1'b0)));
    dir_rows.push_back(typed_row(CODE_BELL, word_of(8'd0, 1'b0, 8'h00, 9'd0, 9'd0, 8'd7, 1'b1)));
    dir_rows.push_back(typed_row(8'hFF, word_of(8'd0, 1'b1, 8'hFF, 9'd0, 9'd1, 8'd7, 1'b0)));
    // a control code with no meaning of its own is written as a glyph
    dir_rows.push_back(typed_row(8'h00, word_of(8'd0, 1'b1, 8'h00, 9'd0, 9'd2, 8'd7, 1'b0)));
    dir_rows.push_back(typed_row(CODE_CR, word_of(8'd0, 1'b0, 8'h00, 9'd0, 9'd0, 8'd7, 1'b0)));
    // backspace at top-left goes nowhere
    dir_rows.push_back(typed_row(CODE_BACKSPACE,
                                 word_of(8'd0, 1'b0, 8'h00, 9'd0, 9'd0, 8'd7, 1'b0)));
    dir_rows.push_back(char_row(CODE_LF));
    dir_rows.push_back(char_row(CODE_BACKSPACE));   // reverse wrap to the row above
    dir_rows.push_back(char_row(CODE_RIGHT));       // park the cursor past the right edge
    dir_rows.push_back(char_row(8'h42));            // wrap, then write
    dir_rows.push_back(char_row(CODE_LEFT));
    dir_rows.push_back(char_row(CODE_LEFT));
    dir_rows.push_back(char_row(CODE_ROW_DEC));
    dir_rows.push_back(char_row(CODE_ROW_DEC));
    dir_rows.push_back(char_row(CODE_ROW_INC));
    dir_rows.push_back(char_row(CODE_HOME));
    dir_rows.push_back(typed_row(CODE_FF, word_of(8'd25, 1'b0, 8'h00, 9'd0, 9'd0, 8'd7, 1'b0)));
    // single-cell window at the far corner: every move wraps or scrolls
    dir_rows.push_back(reg_row(REG_WIN_COL, 8'hFF));
    dir_rows.push_back(reg_row(REG_WIN_ROW, 8'hFF));
    dir_rows.push_back(reg_row(REG_WIN_WIDTH, 8'd1));
    dir_rows.push_back(reg_row(REG_WIN_HEIGHT, 8'd1));
    dir_rows.push_back(reg_row(REG_TEXT_COLOR, 8'hFF));
    dir_rows.push_back(char_row(8'h5A));
    dir_rows.push_back(char_row(8'h59));
    dir_rows.push_back(char_row(CODE_ROW_INC));
    dir_rows.push_back(char_row(CODE_FF));          // wrap scroll plus form-feed scroll
    // zero width and height behave as one
    dir_rows.push_back(reg_row(REG_WIN_WIDTH, 8'd0));
    dir_rows.push_back(reg_row(REG_WIN_HEIGHT, 8'd0));
    dir_rows.push_back(reg_row(REG_TEXT_COLOR, 8'h00));
    dir_rows.push_back(char_row(8'h01));
    dir_rows.push_back(char_row(CODE_BACKSPACE));
    // largest window
    dir_rows.push_back(reg_row(REG_WIN_COL, 8'h00));
    dir_rows.push_back(reg_row(REG_WIN_ROW, 8'h00));
    dir_rows.push_back(reg_row(REG_WIN_WIDTH, 8'hFF));
    dir_rows.push_back(reg_row(REG_WIN_HEIGHT, 8'hFF));
    dir_rows.push_back(reg_row(REG_TEXT_COLOR, 8'h5A));
    dir_rows.push_back(char_row(8'h7F));
    dir_rows.push_back(char_row(CODE_LF));
    dir_rows.push_back(char_row(8'h20));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed rows with no idling on either side
    set_idle(IDLE_NONE);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain_words(4);
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_code(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].word);
        n_directed++;
      end
    end

    // Random phases: new window each time, idling pattern cycles through all four
    for (int p = 0; p < 8; p++) begin
      drain_words(4);
      if (p == 0) begin
        phase_cfg = '0;
      end else if (p == 1) begin
        phase_cfg = '1;
      end else begin
        phase_cfg.win_col    = pick_reg_value(REG_WIN_COL);
        phase_cfg.win_row    = pick_reg_value(REG_WIN_ROW);
        phase_cfg.win_width  = pick_reg_value(REG_WIN_WIDTH);
        phase_cfg.win_height = pick_reg_value(REG_WIN_HEIGHT);
        phase_cfg.text_color = pick_reg_value(REG_TEXT_COLOR);
      end
      write_window(phase_cfg);
      set_idle(idle_mode_e'(p % 4));
      for (int k = 0; k < 50; k++) begin
        // hold off the result side for a long stretch so the engine backs up
        if (p == 2 && k == 5) hold_tag <= hold_tag + 1;
        // pause the sender until every owed word is back
        if (p == 5 && k == 25) drain_words(0);
        send_code(pick_code(), 1'b0, '0);
        n_random++;
      end
    end

    // Tall sweep: walk the cursor down a 255-row window to push it off the bottom,
    // then form-feed so the scroll count saturates
    drain_words(4);
    phase_cfg.win_col    = pick_reg_value(REG_WIN_COL);
    phase_cfg.win_row    = pick_reg_value(REG_WIN_ROW);
    phase_cfg.win_width  = 8'($urandom_range(3, 1));
    phase_cfg.win_height = 8'hFF;
    phase_cfg.text_color = pick_reg_value(REG_TEXT_COLOR);
    write_window(phase_cfg);
    set_idle(IDLE_BOTH);
    send_code(CODE_HOME, 1'b0, '0);
    for (int k = 0; k < 300; k++) begin
      if ($urandom_range(99) < 70)
        code_v = $urandom_range(1) ? CODE_LF : CODE_ROW_INC;
      else
        code_v = 8'($urandom_range(255, 32));
      send_code(code_v, 1'b0, '0);
      n_random++;
    end
    send_code(CODE_FF, 1'b0, '0);
    send_code(CODE_FF, 1'b0, '0);
    n_random += 3;

    drain_words(6);
    $display("Checked %0d result words: %0d directed and %0d random characters",
             words_checked, n_directed, n_random);
    $display("over %0d window settings, largest scroll %0d, %0d mismatches",
             n_settings, max_scroll, errors);
    if (errors == 0) begin
      $display("tb_text_window_cursor_engine_top OK");
    end else begin
      $display("tb_text_window_cursor_engine_top NOT OK");
    end
    $finish;
  end

endmodule
